// ----- sv/sawarq_pkg.sv -----
`default_nettype none
package sawarq_pkg;

  localparam logic [1:0] ACT_PAYLOAD  = 2'd0;
  localparam logic [1:0] ACT_RESPONSE = 2'd1;
  localparam logic [1:0] ACT_TICK     = 2'd2;

  localparam logic REG_CHECKSUM_ENABLE = 1'b0;
  localparam logic REG_TIMEOUT_TICKS   = 1'b1;

  localparam logic [7:0]  NAK_BYTE      = 8'd78;
  localparam logic [7:0]  NUL_BYTE      = 8'd0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;
  localparam logic [7:0]  SEQ_RESET     = 8'd1;

  typedef enum logic [2:0] {
    EV_NEW       = 3'd0,
    EV_NAK       = 3'd1,
    EV_CSUM_ERR  = 3'd2,
    EV_TIMEOUT   = 3'd3,
    EV_ACKED     = 3'd4,
    EV_REJECTED  = 3'd5
  } event_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] payload;
    logic [7:0]  resp_byte0;
    logic [7:0]  resp_byte1;
    logic [7:0]  resp_byte2;
    logic [7:0]  resp_byte3;
    logic [7:0]  resp_byte4;
    logic [7:0]  resp_byte5;
  } in_item_t;

  typedef struct packed {
    event_e      event_kind;
    logic [7:0]  frame_seq;
    logic [7:0]  frame_check;
    logic [31:0] frame_payload;
  } out_item_t;

  typedef struct packed {
    logic        checksum_enable;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic        emit;
    event_e      kind;
    logic        load;
    logic [7:0]  new_check;
    logic        wait_d;
    logic [15:0] tick_d;
  } decision_t;

endpackage
`default_nettype wire

// ----- sv/sawarq_if.sv -----
`default_nettype none
interface sawarq_in_if;
  import sawarq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface sawarq_out_if;
  import sawarq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

// ----- sv/stop_and_wait_arq_sender_top.sv -----
`default_nettype none
// Stop-and-wait ARQ sender. Every transaction on the input channel carries one action:
// a new payload, a response or a timer tick. One transaction is accepted in every cycle
// unless the input stalls; the decision logic reads it from the input register and
// computes the new sequence, held frame, waiting flag and tick counter, which are
// registered together with any result in the output register when the input register
// advances. The input stalls only while a result is due and the output register still
// holds an untaken transaction. Configuration must be written through the plain write
// port only while no transaction is in flight; the block does not enforce this. Index 0
// enables checksums, index 1 sets the timeout in ticks.
module stop_and_wait_arq_sender_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  sawarq_in_if.sink        in_i,
  sawarq_out_if.source     out_o
);
  import sawarq_pkg::*;

  cfg_t      cfg;
  decision_t dec;

  logic        in_valid_q;
  in_item_t    in_item_q;
  logic        waiting_q;
  logic [15:0] tick_q;
  logic [7:0]  next_seq_q;
  logic [7:0]  held_seq_q;
  logic [7:0]  held_check_q;
  logic [31:0] held_payload_q;
  logic        out_valid_q;
  out_item_t   out_item_q;
  out_item_t   out_item_d;
  logic        advance;

  sawarq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sawarq_decide u_decide (
    .item_i     (in_item_q),
    .cfg_i      (cfg),
    .waiting_i  (waiting_q),
    .tick_i     (tick_q),
    .next_seq_i (next_seq_q),
    .dec_o      (dec)
  );

  assign advance = in_valid_q && !(dec.emit && out_valid_q && !out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q  <= 1'b0;
      tick_q     <= '0;
      next_seq_q <= SEQ_RESET;
    end else if (advance) begin
      waiting_q <= dec.wait_d;
      tick_q    <= dec.tick_d;
      if (dec.load) begin
        next_seq_q <= next_seq_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && dec.load) begin
      held_seq_q     <= next_seq_q;
      held_check_q   <= dec.new_check;
      held_payload_q <= in_item_q.payload;
    end
  end

  always_comb begin
    out_item_d.event_kind = dec.kind;
    if (dec.load) begin
      out_item_d.frame_seq     = next_seq_q;
      out_item_d.frame_check   = dec.new_check;
      out_item_d.frame_payload = in_item_q.payload;
    end else begin
      out_item_d.frame_seq     = held_seq_q;
      out_item_d.frame_check   = held_check_q;
      out_item_d.frame_payload = held_payload_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && dec.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && dec.emit) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;
endmodule
`default_nettype wire

// ----- sv/sawarq_cfg.sv -----
`default_nettype none
module sawarq_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  output sawarq_pkg::cfg_t cfg_o
);
  import sawarq_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.checksum_enable <= 1'b0;
      cfg_q.timeout_ticks   <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CHECKSUM_ENABLE: cfg_q.checksum_enable <= cfg_wdata_i[0];
        REG_TIMEOUT_TICKS:   cfg_q.timeout_ticks   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

// ----- sv/sawarq_decide.sv -----
`default_nettype none
module sawarq_decide (
  input  wire sawarq_pkg::in_item_t item_i,
  input  wire sawarq_pkg::cfg_t     cfg_i,
  input  wire logic                 waiting_i,
  input  wire logic [15:0]          tick_i,
  input  wire logic [7:0]           next_seq_i,
  output sawarq_pkg::decision_t     dec_o
);
  import sawarq_pkg::*;

  logic [7:0]  frame_sum;
  logic [7:0]  resp_sum;
  logic [7:0]  kind_byte;
  logic        nz3;
  logic        nz4;
  logic        nz5;
  logic [16:0] tick_next;

  assign frame_sum = item_i.payload[31:24] + item_i.payload[23:16]
                   + item_i.payload[15:8] + item_i.payload[7:0] + next_seq_i;

  // Response bytes three to five are summed up to the first zero byte.
  assign nz3 = (item_i.resp_byte3 != NUL_BYTE);
  assign nz4 = nz3 && (item_i.resp_byte4 != NUL_BYTE);
  assign nz5 = nz4 && (item_i.resp_byte5 != NUL_BYTE);
  assign resp_sum = (nz3 ? item_i.resp_byte3 : NUL_BYTE)
                  + (nz4 ? item_i.resp_byte4 : NUL_BYTE)
                  + (nz5 ? item_i.resp_byte5 : NUL_BYTE)
                  + item_i.resp_byte0 + item_i.resp_byte1;

  assign kind_byte = cfg_i.checksum_enable ? item_i.resp_byte3 : item_i.resp_byte2;
  assign tick_next = {1'b0, tick_i} + 17'd1;

  always_comb begin
    dec_o           = '0;
    dec_o.kind      = EV_NEW;
    dec_o.wait_d    = waiting_i;
    dec_o.tick_d    = tick_i;
    dec_o.new_check = cfg_i.checksum_enable ? frame_sum : NUL_BYTE;
    case (item_i.action)
      ACT_PAYLOAD: begin
        dec_o.emit = 1'b1;
        if (waiting_i) begin
          dec_o.kind = EV_REJECTED;
        end else begin
          dec_o.kind   = EV_NEW;
          dec_o.load   = 1'b1;
          dec_o.wait_d = 1'b1;
          dec_o.tick_d = '0;
        end
      end
      ACT_RESPONSE: begin
        if (waiting_i) begin
          dec_o.emit   = 1'b1;
          dec_o.tick_d = '0;
          if (cfg_i.checksum_enable && (resp_sum != item_i.resp_byte2)) begin
            dec_o.kind = EV_CSUM_ERR;
          end else if (kind_byte == NAK_BYTE) begin
            dec_o.kind = EV_NAK;
          end else begin
            dec_o.kind   = EV_ACKED;
            dec_o.wait_d = 1'b0;
          end
        end
      end
      ACT_TICK: begin
        if (waiting_i) begin
          if (tick_next >= {1'b0, cfg_i.timeout_ticks}) begin
            dec_o.emit   = 1'b1;
            dec_o.kind   = EV_TIMEOUT;
            dec_o.tick_d = '0;
          end else begin
            dec_o.tick_d = tick_next[15:0];
          end
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- sv/sawarq_checker.sv -----
`default_nettype none
module sawarq_checker (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_i,
  input wire logic                  out_valid_i,
  input wire logic                  out_ready_i,
  input wire sawarq_pkg::out_item_t out_item_i
);
  import sawarq_pkg::*;

  // A stalled result holds its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("stalled result changed");

  // An offered input transaction stalls only behind a result that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // Only defined event kinds are ever delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_item_i.event_kind == EV_NEW)
                 || (out_item_i.event_kind == EV_NAK)
                 || (out_item_i.event_kind == EV_CSUM_ERR)
                 || (out_item_i.event_kind == EV_TIMEOUT)
                 || (out_item_i.event_kind == EV_ACKED)
                 || (out_item_i.event_kind == EV_REJECTED))
    else $error("undefined event kind");
endmodule

bind stop_and_wait_arq_sender_top sawarq_checker u_sawarq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.item)
);
`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none
module tb_top;
  import sawarq_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  class frame_tracker;
    logic        cs_en;
    logic [15:0] timeout;
    logic [7:0]  next_seq;
    logic [7:0]  held_seq;
    logic [7:0]  held_check;
    logic [31:0] held_payload;
    bit          waiting;
    logic [15:0] tick_count;
    out_item_t   due[$];
    int          errors;
    int          handled;

    function new();
      cs_en        = 1'b0;
      timeout      = TIMEOUT_RESET;
      next_seq     = SEQ_RESET;
      held_seq     = '0;
      held_check   = '0;
      held_payload = '0;
      waiting      = 1'b0;
      tick_count   = '0;
      errors       = 0;
      handled      = 0;
    endfunction

    function void push_held(event_e kind);
      out_item_t r;
      r.event_kind    = kind;
      r.frame_seq     = held_seq;
      r.frame_check   = held_check;
      r.frame_payload = held_payload;
      due.push_back(r);
    endfunction

    function void note_action(in_item_t it);
      logic [7:0]  sum;
      logic [7:0]  kind_byte;
      logic [16:0] next;
      logic [7:0]  tail [3];
      bit          stop;
      int          i;
      case (it.action)
        ACT_PAYLOAD: begin
          handled++;
          if (waiting) begin
            push_held(EV_REJECTED);
          end else begin
            sum = it.payload[31:24] + it.payload[23:16] + it.payload[15:8] + it.payload[7:0]
                  + next_seq;
            held_seq     = next_seq;
            held_check   = cs_en ? sum : 8'd0;
            held_payload = it.payload;
            next_seq     = next_seq + 8'd1;
            waiting      = 1'b1;
            tick_count   = '0;
            push_held(EV_NEW);
          end
        end
        ACT_RESPONSE: if (waiting) begin
          handled++;
          tick_count = '0;
          if (cs_en) begin
            tail = '{it.resp_byte3, it.resp_byte4, it.resp_byte5};
            sum  = '0;
            stop = 1'b0;
            for (i = 0; i < 3 && !stop; i++) begin
              if (tail[i] == NUL_BYTE) stop = 1'b1;
              else sum = sum + tail[i];
            end
            sum = sum + it.resp_byte0 + it.resp_byte1;
            if (sum != it.resp_byte2) begin
              push_held(EV_CSUM_ERR);
              return;
            end
            kind_byte = it.resp_byte3;
          end else begin
            kind_byte = it.resp_byte2;
          end
          if (kind_byte == NAK_BYTE) begin
            push_held(EV_NAK);
          end else begin
            waiting = 1'b0;
            push_held(EV_ACKED);
          end
        end
        ACT_TICK: if (waiting) begin
          handled++;
          next = {1'b0, tick_count} + 17'd1;
          if (next >= {1'b0, timeout}) begin
            tick_count = '0;
            push_held(EV_TIMEOUT);
          end else begin
            tick_count = next[15:0];
          end
        end
        default: ;
      endcase
    endfunction

    function void check_event(out_item_t got);
      out_item_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected result, kind %0d seq %0h", $time, got.event_kind,
                 got.frame_seq);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got.event_kind !== want.event_kind) begin
        $display("%0t: event_kind expected %0d, actual %0d", $time, want.event_kind,
                 got.event_kind);
        errors++;
      end
      if (got.frame_seq !== want.frame_seq) begin
        $display("%0t: frame_seq expected %0h, actual %0h", $time, want.frame_seq,
                 got.frame_seq);
        errors++;
      end
      if (got.frame_check !== want.frame_check) begin
        $display("%0t: frame_check expected %0h, actual %0h", $time, want.frame_check,
                 got.frame_check);
        errors++;
      end
      if (got.frame_payload !== want.frame_payload) begin
        $display("%0t: frame_payload expected %0h, actual %0h", $time, want.frame_payload,
                 got.frame_payload);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  sawarq_in_if  in_ch ();
  sawarq_out_if out_ch ();

  stop_and_wait_arq_sender_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch.sink),
    .out_o       (out_ch.source)
  );

  frame_tracker tracker = new();

  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_left   = 0;
  int press_count = 0;
  int press_taken = 0;
  bit cur_cs      = 1'b0;
  int cycles      = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (press_count != press_taken) begin
      hold_left   = 400;
      press_taken = press_count;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) tracker.check_event(out_ch.item);
      if (in_ch.valid && in_ch.ready) tracker.note_action(in_ch.item);
    end
  end

  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.due.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_config(input bit cs, input logic [15:0] ticks);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_CHECKSUM_ENABLE;
    cfg_wdata_i <= {15'd0, cs};
    @(posedge clk_i);
    cfg_idx_i   <= REG_TIMEOUT_TICKS;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    tracker.cs_en   = cs;
    tracker.timeout = ticks;
    cur_cs          = cs;
  endtask

  function automatic in_item_t make_item(input logic [1:0] act, input logic [31:0] pl);
    in_item_t it;
    it.action     = act;
    it.payload    = pl;
    it.resp_byte0 = 8'($urandom);
    it.resp_byte1 = 8'($urandom);
    it.resp_byte2 = 8'($urandom);
    it.resp_byte3 = 8'($urandom);
    it.resp_byte4 = 8'($urandom);
    it.resp_byte5 = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t response(input logic [7:0] b0, b1, b2, b3, b4, b5);
    in_item_t it;
    it = make_item(ACT_RESPONSE, $urandom);
    it.resp_byte0 = b0;
    it.resp_byte1 = b1;
    it.resp_byte2 = b2;
    it.resp_byte3 = b3;
    it.resp_byte4 = b4;
    it.resp_byte5 = b5;
    return it;
  endfunction

  // Sum that a well-formed response carries when checksums are on.
  function automatic logic [7:0] good_sum(input logic [7:0] b0, b1, b3, b4, b5);
    logic [7:0] s;
    s = '0;
    if (b3 != NUL_BYTE) begin
      s = s + b3;
      if (b4 != NUL_BYTE) begin
        s = s + b4;
        if (b5 != NUL_BYTE) s = s + b5;
      end
    end
    return s + b0 + b1;
  endfunction

  function automatic logic [7:0] not_nak();
    logic [7:0] r;
    r = 8'($urandom);
    if (r == NAK_BYTE) r = r + 8'd1;
    return r;
  endfunction

  task automatic send_response(input bit nak, input bit corrupt);
    logic [7:0] b0, b1, b2, b3, b4, b5;
    b0 = 8'($urandom);
    b1 = tracker.held_seq;
    if (cur_cs) begin
      b3 = nak ? NAK_BYTE : (($urandom_range(0, 9) == 0) ? NUL_BYTE : not_nak());
      b4 = ($urandom_range(0, 4) == 0) ? NUL_BYTE : 8'($urandom);
      b5 = ($urandom_range(0, 4) == 0) ? NUL_BYTE : 8'($urandom);
      b2 = good_sum(b0, b1, b3, b4, b5) + (corrupt ? 8'($urandom_range(1, 255)) : 8'd0);
    end else begin
      b2 = corrupt ? 8'($urandom) : (nak ? NAK_BYTE : not_nak());
      b3 = 8'($urandom);
      b4 = 8'($urandom);
      b5 = 8'($urandom);
    end
    send_item(response(b0, b1, b2, b3, b4, b5));
  endtask

  task automatic run_exchange();
    int steps;
    int r;
    bit done;
    send_item(make_item(ACT_PAYLOAD, $urandom));
    steps = $urandom_range(1, 6);
    done  = 1'b0;
    while (steps > 0 && !done) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        repeat ($urandom_range(1, 8)) send_item(make_item(ACT_TICK, $urandom));
      end else if (r < 45) begin
        send_response(1'b1, 1'b0);
      end else if (r < 55) begin
        send_response(1'($urandom_range(0, 1)), 1'b1);
      end else if (r < 62) begin
        send_item(make_item(ACT_PAYLOAD, $urandom));
      end else if (r < 66) begin
        send_item(make_item(2'd3, $urandom));
      end else begin
        send_response(1'b0, 1'b0);
        done = ($urandom_range(0, 9) < 7);
      end
      steps--;
    end
    if (!done && $urandom_range(0, 9) != 0) send_response(1'b0, 1'b0);
    if ($urandom_range(0, 19) == 0) send_item(make_item(ACT_TICK, $urandom));
  endtask

  task automatic run_phase(input bit cs, input logic [15:0] ticks, input int idle,
                           input int stall, input int target, input bit press);
    int start;
    settle();
    write_config(cs, ticks);
    idle_pct  = idle;
    stall_pct = stall;
    if (press) press_count++;
    start = tracker.handled;
    while (tracker.handled - start < target) run_exchange();
  endtask

  initial begin
    logic [7:0] b0, b1;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_CHECKSUM_ENABLE;
    cfg_wdata_i  <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.item   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_item(make_item(ACT_TICK, $urandom));
    send_item(make_item(ACT_RESPONSE, $urandom));
    send_item(make_item(2'd3, $urandom));
    send_item(make_item(ACT_PAYLOAD, 32'hFFFF_FFFF));
    send_item(make_item(ACT_PAYLOAD, 32'h0000_0000));
    send_response(1'b1, 1'b0);
    send_item(make_item(ACT_TICK, $urandom));
    send_item(response(8'hFF, 8'h00, NUL_BYTE, 8'hFF, 8'hFF, 8'hFF));

    settle();
    write_config(1'b1, 16'd1);
    send_item(make_item(ACT_PAYLOAD, 32'h0000_0000));
    send_item(make_item(ACT_TICK, $urandom));
    send_response(1'b0, 1'b1);
    send_response(1'b1, 1'b0);
    b0 = 8'($urandom);
    b1 = 8'($urandom);
    send_item(response(b0, b1, b0 + b1, NUL_BYTE, 8'hFF, 8'hFF));
    send_item(make_item(ACT_PAYLOAD, 32'h1234_5678));
    send_item(response(b0, b1, good_sum(b0, b1, 8'd65, NUL_BYTE, 8'hFF), 8'd65, NUL_BYTE,
                       8'hFF));
    send_item(make_item(ACT_PAYLOAD, 32'hFFFF_FFFF));
    send_item(make_item(2'd3, 32'hFFFF_FFFF));
    send_item(response(8'hFF, 8'hFF, good_sum(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 8'hFF,
                       8'hFF, 8'hFF));

    run_phase(1'b1, 16'd3, 0, 0, 230, 1'b0);
    run_phase(1'b0, 16'd1, 60, 0, 230, 1'b0);
    run_phase(1'b1, 16'd65535, 0, 60, 230, 1'b0);
    run_phase(1'b1, 16'd5, 33, 33, 230, 1'b0);
    run_phase(1'b0, 16'd2, 0, 0, 230, 1'b1);
    run_phase(1'b1, 16'd1, 0, 0, 230, 1'b0);

    settle();
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
